>>> sv/tun_pkg.sv
// shared widths and pipeline types for the triangle unit normal block
// no dependencies; imported by every module of the block
package tun_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;

    localparam int OUT_WIDTH  = 16;                    // output field width
    localparam int NUM_FIELDS = 9;                     // coordinates per transfer
    localparam int IN_BYTES   = (NUM_FIELDS * COORD_WIDTH + 7) / 8;
    localparam int IN_TDATA_W = IN_BYTES * 8;
    localparam int OUT_BYTES  = (3 * OUT_WIDTH + 7) / 8;
    localparam int OUT_TDATA_W = OUT_BYTES * 8;

    localparam int DIFF_W = COORD_WIDTH + 1;           // edge vector component
    localparam int PROD_W = 2 * DIFF_W;                // signed edge product
    localparam int MAG_W  = PROD_W;                    // cross component magnitude
    localparam int SQ_W   = 2 * MAG_W;                 // squared magnitude
    localparam int SUM_W  = SQ_W + 2;                  // sum of three squares
    localparam int ROOT_W = NORMAL_FRAC_BITS + 2;      // bits of doubled quotient
    localparam int ACC_W  = SUM_W + 2 * ROOT_W;        // residual and partial sums
    localparam int RSHIFT = 2 * NORMAL_FRAC_BITS + 2;  // scale of the squared numerator

    // per-component state of the digit recurrence
    typedef struct packed {
        logic [ACC_W-1:0]  rem;    // scaled numerator minus t^2 * s
        logic [ACC_W-1:0]  part;   // s * t, aligned to the current digit
        logic [ROOT_W-1:0] root;   // quotient bits found so far
        logic              neg;    // sign of the cross component
    } lane_t;

    // one pipeline slot of the normalization recurrence
    typedef struct packed {
        lane_t [2:0]       lane;
        logic [ACC_W-1:0]  step;   // s aligned to the current digit
        logic              zero;   // cross product is the zero vector
    } root_slot_t;

endpackage

>>> sv/triangle_unit_normal.sv
// throughput: one triangle per cycle; the whole pipeline advances together
// and holds while a finished result waits for m_tready
// reset: aresetn low clears every valid bit; data registers keep their contents
// depends on tun_pkg, tun_cross and tun_root_step
module triangle_unit_normal
    import tun_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // normal_x, normal_y, normal_z
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // degenerate
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    logic en;

    logic              cr_valid;
    logic [2:0][MAG_W-1:0] cr_mag;
    logic [2:0]        cr_neg;

    logic              sq_vld_reg;
    logic [SQ_W-1:0]   sq_reg [3];
    logic [2:0]        sq_neg_reg;

    logic              init_vld_reg;
    root_slot_t        init_slot_reg;
    logic [SUM_W-1:0]  sum;

    logic              rv [ROOT_W+1];
    root_slot_t        rs [ROOT_W+1];

    logic              out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic              out_degen_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic [OUT_WIDTH+ROOT_W-1:0] kx [3];

    // the whole pipeline moves unless a result is stuck at the output
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    tun_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_coord  (s_tdata[NUM_FIELDS*COORD_WIDTH-1:0]),
        .out_valid (cr_valid),
        .out_mag   (cr_mag),
        .out_neg   (cr_neg)
    );

    // squares of the cross components
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg <= cr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQ_W'(cr_mag[i]) * SQ_W'(cr_mag[i]);
            end
            sq_neg_reg <= cr_neg;
        end
    end

    // squared magnitude and recurrence start
    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_vld_reg <= 1'b0;
        end else if (en) begin
            init_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            init_slot_reg.step <= ACC_W'(sum) << (2 * (ROOT_W - 1));
            init_slot_reg.zero <= (sum == '0);
            for (int i = 0; i < 3; i++) begin
                init_slot_reg.lane[i].rem  <= ACC_W'(sq_reg[i]) << RSHIFT;
                init_slot_reg.lane[i].part <= '0;
                init_slot_reg.lane[i].root <= '0;
                init_slot_reg.lane[i].neg  <= sq_neg_reg[i];
            end
        end
    end

    assign rv[0] = init_vld_reg;
    assign rs[0] = init_slot_reg;

    // one stage per quotient digit, most significant first
    for (genvar g = 0; g < ROOT_W; g++) begin : g_root
        tun_root_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (rv[g]),
            .in_slot   (rs[g]),
            .out_valid (rv[g+1]),
            .out_slot  (rs[g+1])
        );
    end

    // round half away from zero, apply sign, pack
    always_comb begin
        out_data_next = '0;
        for (int i = 0; i < 3; i++) begin
            kx[i] = (OUT_WIDTH+ROOT_W)'(rs[ROOT_W].lane[i].root)
                  + (OUT_WIDTH+ROOT_W)'(1);
            kx[i] = kx[i] >> 1;
            if (rs[ROOT_W].lane[i].neg) begin
                kx[i] = -kx[i];
            end
            if (!rs[ROOT_W].zero) begin
                out_data_next[i*OUT_WIDTH +: OUT_WIDTH] = kx[i][OUT_WIDTH-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= rv[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= rs[ROOT_W].zero;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

    // a degenerate result carries a zero normal
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero normal");

    // a stalled result is held unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // input is taken exactly when the pipeline advances
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow pipeline enable");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

>>> sv/tun_cross.sv
// edge vectors and exact cross product, four register stages
// depends on tun_pkg
module tun_cross
    import tun_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [NUM_FIELDS*COORD_WIDTH-1:0] in_coord,
    output logic                         out_valid,
    output logic [2:0][MAG_W-1:0]        out_mag,
    output logic [2:0]                   out_neg
);

    logic [3:0] vld_reg;

    logic signed [DIFF_W-1:0] u_reg [3];
    logic signed [DIFF_W-1:0] v_reg [3];
    logic signed [PROD_W-1:0] pa_reg [3];
    logic signed [PROD_W-1:0] pb_reg [3];
    logic signed [PROD_W:0]   c_reg [3];
    logic [2:0][MAG_W-1:0]    mag_reg;
    logic [2:0]               neg_reg;

    logic signed [COORD_WIDTH-1:0] pt [NUM_FIELDS];

    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            pt[i] = signed'(in_coord[i*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // edge vectors u = p2 - p1, v = p3 - p1
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= DIFF_W'(pt[3+i]) - DIFF_W'(pt[i]);
                v_reg[i] <= DIFF_W'(pt[6+i]) - DIFF_W'(pt[i]);
            end
            // cross product terms
            pa_reg[0] <= u_reg[1] * v_reg[2];
            pb_reg[0] <= u_reg[2] * v_reg[1];
            pa_reg[1] <= u_reg[2] * v_reg[0];
            pb_reg[1] <= u_reg[0] * v_reg[2];
            pa_reg[2] <= u_reg[0] * v_reg[1];
            pb_reg[2] <= u_reg[1] * v_reg[0];
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= (PROD_W+1)'(pa_reg[i]) - (PROD_W+1)'(pb_reg[i]);
            end
            // sign and magnitude
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= c_reg[i][PROD_W];
                mag_reg[i] <= c_reg[i][PROD_W] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
            end
        end
    end

    assign out_valid = vld_reg[3];
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;

endmodule

>>> sv/tun_root_step.sv
// one digit of the quotient c * 2^F / sqrt(s) for all three components
// depends on tun_pkg; one register stage
module tun_root_step
    import tun_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  root_slot_t in_slot,
    output logic       out_valid,
    output root_slot_t out_slot
);

    logic       vld_reg;
    root_slot_t slot_reg;
    root_slot_t slot_next;

    logic [ACC_W:0] trial [3];
    logic [ACC_W:0] diff  [3];
    logic           take  [3];

    // accept the digit when t^2 * s does not pass the scaled numerator
    always_comb begin
        slot_next      = in_slot;
        slot_next.step = in_slot.step >> 2;
        for (int i = 0; i < 3; i++) begin
            trial[i] = (ACC_W+1)'(in_slot.lane[i].part) + (ACC_W+1)'(in_slot.step);
            diff[i]  = (ACC_W+1)'(in_slot.lane[i].rem) - trial[i];
            take[i]  = !diff[i][ACC_W];
            slot_next.lane[i].rem  = take[i] ? diff[i][ACC_W-1:0] : in_slot.lane[i].rem;
            slot_next.lane[i].part = take[i] ? (in_slot.lane[i].part >> 1) + in_slot.step
                                             : (in_slot.lane[i].part >> 1);
            slot_next.lane[i].root = {in_slot.lane[i].root[ROOT_W-2:0], take[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            slot_reg <= slot_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_slot  = slot_reg;

endmodule
